>>> rtl/command_line_argument_splitter_top_macros.svh
// assertion macros for the command line argument splitter
`ifndef COMMAND_LINE_ARGUMENT_SPLITTER_TOP_MACROS_SVH
`define COMMAND_LINE_ARGUMENT_SPLITTER_TOP_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define CLAS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define CLAS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/clas_pkg.sv
// types, codes and helpers shared by the command line argument splitter
package clas_pkg;

    // default bound on a held backslash run
    localparam int MAX_SLASH_RUN_DEF = 62;

    localparam logic [7:0] QUOTE_CHAR = 8'h22;
    localparam logic [7:0] SLASH_CHAR = 8'h5C;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] TAB_CHAR   = 8'h09;
    localparam logic [7:0] CR_CHAR    = 8'h0D;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_LITERAL  = 2'd0,
        KIND_END_ARG  = 2'd1,
        KIND_END_LINE = 2'd2
    } kind_t;

    // quote tracking state
    typedef enum logic [2:0] {
        QM_OUTSIDE = 3'b001,
        QM_INSIDE  = 3'b010,
        QM_CLOSED  = 3'b100
    } quote_mode_t;

    // space, tab, lf, vt, ff, cr
    function automatic logic is_blank(input logic [7:0] c);
        return (c == SPACE_CHAR) || ((c >= TAB_CHAR) && (c <= CR_CHAR));
    endfunction

endpackage

>>> rtl/command_line_argument_splitter_top.sv
// command line argument splitter: byte stream in, argument word items out
//
// Takes one byte of the command line per transfer and returns literal bytes, end-of-argument
// marks and a final end-of-line mark. An ordinary byte is taken every cycle while m_tready
// is high and gives at most one result in the next cycle. A byte that releases a held run
// of n backslashes gives them ahead of its own result; a quote after such a run gives n/2
// of them (rounded down), then a literal quote if one is due. The end of line gives the run,
// an end-of-argument mark if a word is open, then the end-of-line mark; the result register
// hands out one item per cycle while m_tready is high. The input side accepts the next byte
// in the cycle the previous byte's last result goes out, so s_tready depends on m_tready too.
module command_line_argument_splitter_top
    import clas_pkg::*;
#(
    parameter int MAX_SLASH_RUN = MAX_SLASH_RUN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic       s_tlast,   // line_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] kind
    output logic       m_tlast    // last_of_run
);

    localparam int SLASH_W = $clog2(MAX_SLASH_RUN + 1);
    localparam logic [SLASH_W-1:0] SLASH_MAX = SLASH_W'(MAX_SLASH_RUN);
    localparam logic [SLASH_W-1:0] SLASH_ONE = SLASH_W'(1);

    // parse state
    logic               in_word_reg, in_word_next;
    quote_mode_t        qm_reg, qm_next;
    logic [SLASH_W-1:0] pend_reg, pend_next;

    // result job: backslash run, then up to two tail items
    logic [SLASH_W-1:0] cnt_reg, cnt_next;
    logic               t0_valid_reg, t0_valid_next;
    kind_t              t0_kind_reg, t0_kind_next;
    logic [7:0]         t0_byte_reg, t0_byte_next;
    logic               t1_valid_reg, t1_valid_next;

    // job load values for the byte in flight
    logic [SLASH_W-1:0] ld_cnt;
    logic               ld_t0;
    kind_t              ld_kind;
    logic [7:0]         ld_byte;
    logic               ld_t1;

    logic        busy;
    logic        cur_slash;
    logic        in_xfer;
    logic        out_xfer;
    quote_mode_t qm_open;
    quote_mode_t qm_begin;

    // result side
    assign busy      = (cnt_reg != '0) || t0_valid_reg || t1_valid_reg;
    assign cur_slash = (cnt_reg != '0);
    assign m_tvalid  = busy;

    always_comb
    begin
        if (cur_slash)
        begin
            m_tuser = KIND_LITERAL;
            m_tdata = SLASH_CHAR;
            m_tlast = (cnt_reg == SLASH_ONE) && !t0_valid_reg && !t1_valid_reg;
        end
        else if (t0_valid_reg)
        begin
            m_tuser = t0_kind_reg;
            m_tdata = t0_byte_reg;
            m_tlast = !t1_valid_reg;
        end
        else
        begin
            m_tuser = KIND_END_LINE;
            m_tdata = 8'h00;
            m_tlast = 1'b1;
        end
    end

    assign out_xfer = m_tvalid && m_tready;
    assign s_tready = !busy || (m_tready && m_tlast);
    assign in_xfer  = s_tvalid && s_tready;

    // parse one byte against the current state
    always_comb
    begin
        in_word_next = in_word_reg;
        qm_next      = qm_reg;
        pend_next    = pend_reg;
        ld_cnt       = '0;
        ld_t0        = 1'b0;
        ld_kind      = KIND_LITERAL;
        ld_byte      = 8'h00;
        ld_t1        = 1'b0;

        // open word keeps its mode (qm_open: closed to outside); new word starts outside
        qm_open  = (in_word_reg && (qm_reg == QM_CLOSED)) ? QM_OUTSIDE : qm_reg;
        qm_begin = in_word_reg ? qm_reg : QM_OUTSIDE;

        if (s_tlast)
        begin
            // end of line: copy held run, close word, mark line end, clear state
            ld_cnt       = pend_reg;
            ld_t0        = in_word_reg;
            ld_kind      = KIND_END_ARG;
            ld_t1        = 1'b1;
            in_word_next = 1'b0;
            qm_next      = QM_OUTSIDE;
            pend_next    = '0;
        end
        else if (s_tdata == QUOTE_CHAR)
        begin
            in_word_next = 1'b1;
            pend_next    = '0;
            ld_cnt       = pend_reg >> 1;
            if (pend_reg[0])
            begin
                // odd run escapes this quote
                qm_next = qm_begin;
                ld_t0   = 1'b1;
                ld_byte = QUOTE_CHAR;
            end
            else
            begin
                case (qm_begin)
                    QM_OUTSIDE: qm_next = QM_INSIDE;
                    QM_INSIDE:  qm_next = QM_CLOSED;
                    QM_CLOSED:
                    begin
                        qm_next = QM_OUTSIDE;
                        ld_t0   = 1'b1;
                        ld_byte = QUOTE_CHAR;
                    end
                    default:    qm_next = QM_OUTSIDE;
                endcase
            end
        end
        else if (s_tdata == SLASH_CHAR)
        begin
            // hold the backslash, saturating at the bound
            in_word_next = 1'b1;
            qm_next      = in_word_reg ? qm_open : QM_OUTSIDE;
            if (pend_reg < SLASH_MAX)
            begin
                pend_next = pend_reg + SLASH_ONE;
            end
        end
        else if (is_blank(s_tdata))
        begin
            if (in_word_reg)
            begin
                ld_cnt    = pend_reg;
                pend_next = '0;
                if (qm_open == QM_INSIDE)
                begin
                    qm_next = qm_open;
                    ld_t0   = 1'b1;
                    ld_byte = s_tdata;
                end
                else
                begin
                    ld_t0        = 1'b1;
                    ld_kind      = KIND_END_ARG;
                    in_word_next = 1'b0;
                    qm_next      = QM_OUTSIDE;
                end
            end
        end
        else
        begin
            // ordinary literal byte
            in_word_next = 1'b1;
            qm_next      = in_word_reg ? qm_open : QM_OUTSIDE;
            ld_cnt       = pend_reg;
            pend_next    = '0;
            ld_t0        = 1'b1;
            ld_byte      = s_tdata;
        end
    end

    // job register update: drain one item per transfer, load on input transfer
    always_comb
    begin
        cnt_next      = cnt_reg;
        t0_valid_next = t0_valid_reg;
        t0_kind_next  = t0_kind_reg;
        t0_byte_next  = t0_byte_reg;
        t1_valid_next = t1_valid_reg;

        if (out_xfer)
        begin
            if (cur_slash)
            begin
                cnt_next = cnt_reg - SLASH_ONE;
            end
            else if (t0_valid_reg)
            begin
                t0_valid_next = 1'b0;
            end
            else
            begin
                t1_valid_next = 1'b0;
            end
        end

        if (in_xfer)
        begin
            cnt_next      = ld_cnt;
            t0_valid_next = ld_t0;
            t0_kind_next  = ld_kind;
            t0_byte_next  = ld_byte;
            t1_valid_next = ld_t1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg  <= 1'b0;
            qm_reg       <= QM_OUTSIDE;
            pend_reg     <= '0;
            cnt_reg      <= '0;
            t0_valid_reg <= 1'b0;
            t1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                in_word_reg <= in_word_next;
                qm_reg      <= qm_next;
                pend_reg    <= pend_next;
            end
            cnt_reg      <= cnt_next;
            t0_valid_reg <= t0_valid_next;
            t1_valid_reg <= t1_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        t0_kind_reg <= t0_kind_next;
        t0_byte_reg <= t0_byte_next;
    end

    // checks
    `include "command_line_argument_splitter_top_macros.svh"

    `CLAS_ASSERT_ALWAYS(a_pend_bound, pend_reg <= SLASH_MAX, "held backslash run over bound")
    `CLAS_ASSERT_IMPLIES(a_take_only_on_last, in_xfer && busy, out_xfer && m_tlast, "byte taken while results still pending")
    `CLAS_ASSERT_IMPLIES(a_end_line_last, m_tvalid && (m_tuser == KIND_END_LINE), m_tlast, "end of line is not the last result")
    `CLAS_ASSERT_IMPLIES(a_mark_byte_zero, m_tvalid && (m_tuser != KIND_LITERAL), m_tdata == 8'h00, "mark carries a nonzero byte")
    `CLAS_ASSERT_NEXT(a_line_end_clears, in_xfer && s_tlast, !in_word_reg && (pend_reg == '0) && (qm_reg == QM_OUTSIDE), "state not cleared after end of line")

endmodule
